// ----- rtl/integer_to_radix_text_unit_defines.svh -----
// Assertion macros shared by the integer to radix text unit.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTEGER_TO_RADIX_TEXT_UNIT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/itrt_pkg.sv -----
// Package for the integer to radix text unit: types, codes and constants.
// Used by the front end, the job queue and the conversion back end.
package itrt_pkg;

    localparam logic [6:0] CHAR_ZERO    = 7'd48;
    localparam logic [6:0] CHAR_MINUS   = 7'd45;
    localparam logic [6:0] UPPER_OFFSET = 7'd55;
    localparam logic [6:0] LOWER_OFFSET = 7'd87;
    localparam logic [5:0] RADIX_MIN    = 6'd2;
    localparam logic [5:0] RADIX_MAX    = 6'd36;
    localparam logic [5:0] RADIX_RESET  = 6'd10;
    localparam logic [5:0] DIGIT_NINE   = 6'd9;

    typedef enum logic [1:0] {
        CFG_RADIX  = 2'd0,
        CFG_UPPER  = 2'd1,
        CFG_SIGNED = 2'd2,
        CFG_PAD    = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PAD,
        ST_EMIT
    } t_back_state;

    typedef struct packed {
        logic       minus;
        logic       pad;
        logic [5:0] radix;
    } t_job;

    function automatic logic [6:0] digit_char(input logic [5:0] d, input logic upper);
        logic [6:0] d_ext;
        d_ext = {1'b0, d};
        if (d <= DIGIT_NINE) begin
            return d_ext + CHAR_ZERO;
        end
        return d_ext + (upper ? UPPER_OFFSET : LOWER_OFFSET);
    endfunction

endpackage

// ----- rtl/itrt_front.sv -----
// Front end of the integer to radix text unit: configuration registers and classification.
// Splits sign and magnitude, saturates the radix and decides on padding. Uses itrt_pkg.
module itrt_front
    import itrt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_addr,
    input  logic [5:0]             i_cfg_wdata,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_q_full,
    output logic                   o_push,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output t_job                   o_job,
    output logic                   o_upper
);

    logic [5:0] r_radix;
    logic       r_upper;
    logic       r_signed;
    logic       r_pad;

    logic       w_neg;
    logic [5:0] w_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RESET;
            r_upper  <= 1'b0;
            r_signed <= 1'b1;
            r_pad    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_addr))
                CFG_RADIX:  r_radix  <= i_cfg_wdata;
                CFG_UPPER:  r_upper  <= i_cfg_wdata[0];
                CFG_SIGNED: r_signed <= i_cfg_wdata[0];
                CFG_PAD:    r_pad    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_radix < RADIX_MIN) begin
            w_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_radix = RADIX_MAX;
        end else begin
            w_radix = r_radix;
        end
        w_neg       = r_signed && i_value[VALUE_WIDTH-1];
        o_mag       = w_neg ? (~i_value + VALUE_WIDTH'(1)) : i_value;
        o_job.minus = w_neg;
        o_job.radix = w_radix;
        o_job.pad   = !r_signed && r_pad
                      && (i_value < {{(VALUE_WIDTH-6){1'b0}}, w_radix});
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;
    assign o_upper = r_upper;

endmodule

// ----- rtl/itrt_queue.sv -----
// Two-entry job queue between the front end and the conversion back end.
// Holds a magnitude and its job descriptor per entry. Uses itrt_pkg.
module itrt_queue
    import itrt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  t_job                   i_job,
    output logic                   o_full,
    input  logic                   i_pop,
    output logic                   o_valid,
    output logic [VALUE_WIDTH-1:0] o_mag,
    output t_job                   o_job
);

    logic [VALUE_WIDTH-1:0] r_mag [2];
    t_job                   r_job [2];
    logic                   r_wr_ptr;
    logic                   r_rd_ptr;
    logic [1:0]             r_count;

    logic w_do_pop;

    assign w_do_pop = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mag[r_wr_ptr] <= i_mag;
            r_job[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_mag   = r_mag[r_rd_ptr];
    assign o_job   = r_job[r_rd_ptr];

endmodule

// ----- rtl/itrt_back.sv -----
// Conversion back end: bit-serial restoring divider, digit memory and character output.
// Takes jobs from the queue and emits characters most significant first. Uses itrt_pkg.
`include "integer_to_radix_text_unit_defines.svh"

module itrt_back
    import itrt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  logic [VALUE_WIDTH-1:0] i_q_mag,
    input  t_job                   i_q_job,
    output logic                   o_q_pop,
    input  logic                   i_upper,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [6:0]             o_char,
    output logic                   o_last
);

    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    t_back_state            r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [5:0]             r_rem, n_rem;
    logic [5:0]             r_radix, n_radix;
    logic [AW-1:0]          r_bit, n_bit;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_minus, n_minus;
    logic                   r_pad, n_pad;

    logic                   r_a_valid, n_a_valid;
    logic                   r_a_minus, n_a_minus;
    logic                   r_a_last, n_a_last;
    logic                   r_b_valid, n_b_valid;
    logic [6:0]             r_b_char, n_b_char;
    logic                   r_b_last, n_b_last;

    logic [5:0]             r_mem [VALUE_WIDTH];
    logic [5:0]             r_mem_q;

    logic [6:0]             w_trial;
    logic [6:0]             w_diff;
    logic                   w_ge;
    logic [5:0]             w_rem_next;
    logic [VALUE_WIDTH-1:0] w_quot_next;
    logic                   w_out_ready;
    logic                   w_a_free;
    logic                   w_we;
    logic [5:0]             w_wdata;
    logic                   w_rd;
    logic [CW-1:0]          w_rd_idx;

    assign w_trial     = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_diff      = w_trial - {1'b0, r_radix};
    assign w_ge        = (w_trial >= {1'b0, r_radix});
    assign w_rem_next  = w_ge ? w_diff[5:0] : w_trial[5:0];
    assign w_quot_next = {r_quot[VALUE_WIDTH-2:0], w_ge};
    assign w_out_ready = !r_b_valid || i_ready;
    assign w_a_free    = !r_a_valid || w_out_ready;
    assign w_rd_idx    = r_cnt - CW'(1);

    always_comb begin
        n_state   = r_state;
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_radix   = r_radix;
        n_bit     = r_bit;
        n_cnt     = r_cnt;
        n_minus   = r_minus;
        n_pad     = r_pad;
        n_a_valid = r_a_valid;
        n_a_minus = r_a_minus;
        n_a_last  = r_a_last;
        n_b_valid = r_b_valid;
        n_b_char  = r_b_char;
        n_b_last  = r_b_last;
        o_q_pop   = 1'b0;
        w_we      = 1'b0;
        w_wdata   = w_rem_next;
        w_rd      = 1'b0;

        if (w_out_ready) begin
            n_b_valid = r_a_valid;
            n_b_char  = r_a_minus ? CHAR_MINUS : digit_char(r_mem_q, i_upper);
            n_b_last  = r_a_last;
            n_a_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_quot  = i_q_mag;
                    n_rem   = 6'd0;
                    n_bit   = '0;
                    n_cnt   = '0;
                    n_radix = i_q_job.radix;
                    n_minus = i_q_job.minus;
                    n_pad   = i_q_job.pad;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_quot = w_quot_next;
                n_rem  = w_rem_next;
                n_bit  = r_bit + AW'(1);
                if (r_bit == AW'(VALUE_WIDTH - 1)) begin
                    w_we  = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    n_rem = 6'd0;
                    n_bit = '0;
                    if (w_quot_next == '0) begin
                        n_state = r_pad ? ST_PAD : ST_EMIT;
                    end
                end
            end
            ST_PAD: begin
                w_we    = 1'b1;
                w_wdata = 6'd0;
                n_cnt   = r_cnt + CW'(1);
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_a_free) begin
                    n_a_valid = 1'b1;
                    if (r_minus) begin
                        n_a_minus = 1'b1;
                        n_a_last  = 1'b0;
                        n_minus   = 1'b0;
                    end else begin
                        w_rd      = 1'b1;
                        n_a_minus = 1'b0;
                        n_a_last  = (r_cnt == CW'(1));
                        n_cnt     = w_rd_idx;
                        if (r_cnt == CW'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_bit     <= '0;
            r_minus   <= 1'b0;
            r_pad     <= 1'b0;
            r_a_valid <= 1'b0;
            r_a_minus <= 1'b0;
            r_a_last  <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_last  <= 1'b0;
            r_rem     <= 6'd0;
            r_radix   <= RADIX_MIN;
        end else begin
            r_cnt     <= n_cnt;
            r_bit     <= n_bit;
            r_minus   <= n_minus;
            r_pad     <= n_pad;
            r_a_valid <= n_a_valid;
            r_a_minus <= n_a_minus;
            r_a_last  <= n_a_last;
            r_b_valid <= n_b_valid;
            r_b_last  <= n_b_last;
            r_rem     <= n_rem;
            r_radix   <= n_radix;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot   <= n_quot;
        r_b_char <= n_b_char;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_cnt[AW-1:0]] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_mem_q <= r_mem[w_rd_idx[AW-1:0]];
        end
    end

    assign o_valid = r_b_valid;
    assign o_char  = r_b_char;
    assign o_last  = r_b_last;

    `ITRT_ASSERT_SAME(a_rem_below_radix, r_state == ST_DIV, r_rem < r_radix, "Remainder reached the radix.")
    `ITRT_ASSERT_SAME(a_cnt_in_range, 1'b1, r_cnt <= CW'(VALUE_WIDTH), "Digit count overflowed the store.")
    `ITRT_ASSERT_SAME(a_emit_has_digit, r_state == ST_EMIT, r_cnt != '0, "Emission started without digits.")
    `ITRT_ASSERT_NEXT(a_last_ends_job, w_rd && r_cnt == CW'(1), r_state == ST_IDLE, "Final digit did not end the job.")

endmodule

// ----- rtl/integer_to_radix_text_unit.sv -----
// A value is converted by repeated division by the radix in a restoring divider that resolves one
// quotient bit per cycle. The characters then leave most significant first, minus sign first, at
// up to one per cycle. The divider takes the next value only after the last character of the
// current one has entered the first of the two output registers. The divider loop dominates the
// rate, and a stalled output stretches the emission part. A two-entry queue lets the input side
// take values while the back end is busy.
// Top level of the integer to radix text unit; uses itrt_pkg, itrt_front, itrt_queue, itrt_back.
module integer_to_radix_text_unit
    import itrt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_addr,
    input  logic [5:0]                          i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    i_s_tdata,   // value
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [7:0]                          o_m_tdata,   // character, then one zero bit
    output logic                                o_m_tlast
);

    logic                   w_push;
    logic [VALUE_WIDTH-1:0] w_push_mag;
    t_job                   w_push_job;
    logic                   w_q_full;
    logic                   w_q_valid;
    logic                   w_q_pop;
    logic [VALUE_WIDTH-1:0] w_q_mag;
    t_job                   w_q_job;
    logic                   w_upper;
    logic [6:0]             w_char;

    itrt_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_value    (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_mag      (w_push_mag),
        .o_job      (w_push_job),
        .o_upper    (w_upper)
    );

    itrt_queue #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_mag  (w_push_mag),
        .i_job  (w_push_job),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_valid(w_q_valid),
        .o_mag  (w_q_mag),
        .o_job  (w_q_job)
    );

    itrt_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .i_q_mag  (w_q_mag),
        .i_q_job  (w_q_job),
        .o_q_pop  (w_q_pop),
        .i_upper  (w_upper),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_char   (w_char),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

endmodule

// ----- sim/integer_to_radix_text_checker.sv -----
// Checker for the integer to radix text unit: watches the register port and both streams.
// Predicts the characters of every accepted value and compares each output item against them.
// Depends on itrt_pkg for the register indexes and character constants.
module integer_to_radix_text_checker
    import itrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // value
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // character, then one zero bit
    input  logic        i_m_tlast,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    t_text_char text_q[$];
    t_text_char want;
    logic [5:0] radix_reg;
    logic       upper_reg;
    logic       signed_reg;
    logic       pad_reg;
    int         errors = 0;

    function automatic void queue_text_for(input logic [31:0] value);
        logic [5:0]  base;
        logic [31:0] mag;
        logic        neg;
        logic [5:0]  digits[$];
        logic [6:0]  code;
        base = (radix_reg < RADIX_MIN) ? RADIX_MIN :
               ((radix_reg > RADIX_MAX) ? RADIX_MAX : radix_reg);
        neg = signed_reg && value[31];
        mag = neg ? 32'd0 - value : value;
        do begin
            digits.push_front(6'(mag % base));
            mag = mag / base;
        end while (mag != 32'd0);
        if (!signed_reg && pad_reg && value < base) begin
            digits.push_front(6'd0);
        end
        if (neg) begin
            text_q.push_back('{CHAR_MINUS, 1'b0});
        end
        foreach (digits[k]) begin
            if (digits[k] <= DIGIT_NINE) begin
                code = 7'(digits[k]) + CHAR_ZERO;
            end else begin
                code = 7'(digits[k]) + (upper_reg ? UPPER_OFFSET : LOWER_OFFSET);
            end
            text_q.push_back('{code, k == digits.size() - 1});
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_reg  = RADIX_RESET;
            upper_reg  = 1'b0;
            signed_reg = 1'b1;
            pad_reg    = 1'b0;
            text_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_addr))
                    CFG_RADIX:  radix_reg  = i_cfg_wdata;
                    CFG_UPPER:  upper_reg  = i_cfg_wdata[0];
                    CFG_SIGNED: signed_reg = i_cfg_wdata[0];
                    CFG_PAD:    pad_reg    = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_text_for(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (text_q.size() == 0) begin
                    $error("character: expected none, got %0d", i_m_tdata[6:0]);
                    errors++;
                end else begin
                    want = text_q.pop_front();
                    if (i_m_tdata[6:0] !== want.code) begin
                        $error("character: expected %0d, got %0d", want.code, i_m_tdata[6:0]);
                        errors++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_char: expected %0b, got %0b", want.last, i_m_tlast);
                        errors++;
                    end
                    if (i_m_tdata[7] !== 1'b0) begin
                        $error("tdata fill bit: expected 0, got %0b", i_m_tdata[7]);
                        errors++;
                    end
                end
            end
        end
        o_pending <= text_q.size();
        o_errors  <= errors;
    end

endmodule

// ----- sim/tb.sv -----
// Top of the integer to radix text unit testbench: clock, reset, register writes and stimulus.
// Runs directed corner values, then random values under changing settings and flow control.
// Depends on itrt_pkg, integer_to_radix_text_unit and integer_to_radix_text_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import itrt_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = 2'd0;
    logic [5:0]  cfg_wdata = 6'd0;
    logic        s_tvalid  = 1'b0;
    logic [31:0] s_tdata   = 32'd0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    int          pending;
    int          errors;
    int          src_gap_pct   = 0;
    int          sink_gap_pct  = 0;
    int          hold_requests = 0;
    int          holds_done    = 0;

    integer_to_radix_text_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    integer_to_radix_text_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #120_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Output side: random back-pressure, plus a long hold-off whenever one is requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (2000) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= sink_gap_pct);
        end
    end

    task automatic push_value(input logic [31:0] value);
        if ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_values(input logic [31:0] values[$]);
        foreach (values[k]) begin
            push_value(values[k]);
        end
    endtask

    task automatic wait_text_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_settings(input logic [5:0] radix, input logic upper,
                                  input logic sgn, input logic pad);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_RADIX;
        cfg_wdata <= radix;
        @(posedge clk);
        cfg_addr  <= CFG_UPPER;
        cfg_wdata <= {5'd0, upper};
        @(posedge clk);
        cfg_addr  <= CFG_SIGNED;
        cfg_wdata <= {5'd0, sgn};
        @(posedge clk);
        cfg_addr  <= CFG_PAD;
        cfg_wdata <= {5'd0, pad};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [5:0] pick_radix();
        case ($urandom_range(7))
            0: return RADIX_MIN;
            1: return RADIX_MAX;
            2: return 6'($urandom_range(1));
            3: return 6'($urandom_range(63, 37));
            4: return RADIX_RESET;
            default: return 6'($urandom_range(36, 2));
        endcase
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2: return $urandom_range(80);
            3: return 32'd0 - $urandom_range(80, 1);
            4: return $urandom >> $urandom_range(31);
            default: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'd0;
                endcase
            end
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_values('{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'd9, 32'd10});
        wait_text_drained();
        write_settings(RADIX_MAX, 1'b1, 1'b0, 1'b1);
        send_values('{32'd0, 32'd35, 32'd36, 32'hFFFF_FFFF});
        wait_text_drained();
        write_settings(6'd16, 1'b0, 1'b1, 1'b1);
        send_values('{32'd5, 32'hDEAD_BEEF, 32'h0000_00AB});
        wait_text_drained();
        write_settings(RADIX_MIN, 1'b0, 1'b1, 1'b0);
        send_values('{32'h8000_0000, 32'hFFFF_FFFE});
        wait_text_drained();
        write_settings(RADIX_MIN, 1'b1, 1'b0, 1'b1);
        send_values('{32'hFFFF_FFFF, 32'd1});
        wait_text_drained();
        write_settings(6'd0, 1'b0, 1'b0, 1'b0);
        send_values('{32'd5});
        wait_text_drained();
        write_settings(6'd63, 1'b0, 1'b0, 1'b1);
        send_values('{32'd35});
        wait_text_drained();
        write_settings(6'd37, 1'b1, 1'b1, 1'b0);
        send_values('{32'hFFFF_FFDD});

        for (int phase = 0; phase < 3; phase++) begin
            wait_text_drained();
            case (phase)
                0: begin
                    src_gap_pct = 8;
                    sink_gap_pct <= 86;
                end
                1: begin
                    src_gap_pct = 86;
                    sink_gap_pct <= 8;
                end
                default: begin
                    src_gap_pct = 0;
                    sink_gap_pct <= 0;
                end
            endcase
            for (int blk = 0; blk < 6; blk++) begin
                wait_text_drained();
                write_settings(pick_radix(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)));
                if (phase == 2 && blk == 0) begin
                    hold_requests <= hold_requests + 1;
                end
                for (int i = 0; i < 23; i++) begin
                    push_value(random_value());
                    if ($urandom_range(39) == 0) begin
                        wait_text_drained();
                    end
                end
            end
        end

        wait_text_drained();
        repeat (1100) @(posedge clk);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
